// ===== src/icr_pkg.sv =====
// ----------------------------------------------------------------------------
// icr_pkg: shared types and constants for the imu calibrate-and-rotate block
// fixed-point widths, payload structs, lane control and register indexes
// ----------------------------------------------------------------------------
package icr_pkg;

	// number formats
	localparam int SAMPLE_W  = 20;                 // signed sample / offset width
	localparam int COEF_FRAC = 14;                 // fractional bits of scales and matrix
	localparam int COEF_W    = COEF_FRAC + 2;      // Q2.F scale, Q1.F matrix entry
	localparam int NUM_AXES  = 3;

	// datapath widths
	localparam int DIFF_W       = SAMPLE_W + 1;            // raw - offset, exact
	localparam int SCALE_PROD_W = DIFF_W + COEF_W + 1;     // diff * zero-extended scale
	localparam int CORR_W       = SAMPLE_W + 3;            // corrected sample, scale < 4
	localparam int PROD_W       = COEF_W + CORR_W;         // matrix entry * corrected
	localparam int SUM_W        = PROD_W + 2;              // sum of three products
	localparam int RND_W        = SUM_W - COEF_FRAC;       // rounded row sum

	// configuration port
	localparam int NUM_REGS  = 8;
	localparam int CFG_IDX_W = $clog2(NUM_REGS);
	localparam int CFG_W     = (NUM_AXES * SAMPLE_W > NUM_AXES * COEF_W) ?
		NUM_AXES * SAMPLE_W : NUM_AXES * COEF_W;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [COEF_W-1:0] coef_t;
	typedef logic [NUM_AXES-1:0][SAMPLE_W-1:0] sample_vec_t;
	typedef logic [NUM_AXES-1:0][COEF_W-1:0] coef_vec_t;
	typedef logic [NUM_AXES-1:0][PROD_W-1:0] prod_col_t;

	localparam coef_t   COEF_ONE   = COEF_W'(1) << COEF_FRAC;
	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = ~SAMPLE_MAX;

	typedef enum logic {
		KIND_ACCEL = 1'b0,
		KIND_GYRO  = 1'b1
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACCEL_OFFSETS = 3'd0,
		REG_ACCEL_SCALES  = 3'd1,
		REG_ACCEL_CAL_EN  = 3'd2,
		REG_GYRO_OFFSETS  = 3'd3,
		REG_GYRO_CAL_EN   = 3'd4,
		REG_ROT_ROW0      = 3'd5,
		REG_ROT_ROW1      = 3'd6,
		REG_ROT_ROW2      = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		kind_t   opcode;
		sample_t raw_x;
		sample_t raw_y;
		sample_t raw_z;
	} sample_in_t;

	typedef struct packed {
		kind_t   kind;
		sample_t body_x;
		sample_t body_y;
		sample_t body_z;
		logic    saturated;
	} result_t;

	// per-request control handed to every lane
	typedef struct packed {
		kind_t kind;
		logic  accel_cal_en;
		logic  gyro_cal_en;
	} lane_ctl_t;

	// per-axis calibration and one matrix column
	typedef struct packed {
		sample_t   accel_off;
		sample_t   gyro_off;
		coef_t     scale;
		coef_vec_t mcol;       // mcol[r] = m[r][lane]
	} lane_cfg_t;

endpackage

// ===== src/icr_lane.sv =====
// ----------------------------------------------------------------------------
// icr_lane: one sensor axis
// offset removal, scaling with rounding, then the products of this axis with
// its matrix column; four pipeline stages
// ----------------------------------------------------------------------------
module icr_lane
	import icr_pkg::*;
(
	input  logic      clk,
	input  logic      en,
	input  lane_ctl_t ctl,
	input  sample_t   raw,
	input  lane_cfg_t cfg,
	output prod_col_t prod
);

	localparam logic signed [COEF_W:0] SCALE_ONE = (COEF_W + 1)'(1) << COEF_FRAC;
	localparam logic signed [SCALE_PROD_W-1:0] SCALE_HALF =
		SCALE_PROD_W'(1) << (COEF_FRAC - 1);

	logic signed [DIFF_W-1:0]       raw_ext;
	logic signed [DIFF_W-1:0]       acc_diff;
	logic signed [DIFF_W-1:0]       gyro_diff;
	logic signed [SCALE_PROD_W-1:0] sprod_rnd;

	logic signed [DIFF_W-1:0]       diff_s1;
	logic signed [COEF_W:0]         scale_s1;
	logic signed [SCALE_PROD_W-1:0] sprod_s2;
	logic signed [CORR_W-1:0]       corr_s3;
	prod_col_t                      prod_s4;

	always_comb begin
		raw_ext   = DIFF_W'(raw);
		acc_diff  = raw_ext - DIFF_W'(cfg.accel_off);
		gyro_diff = raw_ext - DIFF_W'(cfg.gyro_off);
		sprod_rnd = sprod_s2 + SCALE_HALF;
	end

	// uncalibrated paths go through the multiplier at 1.0 and round back exactly
	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl.kind == KIND_ACCEL) begin
				diff_s1  <= ctl.accel_cal_en ? acc_diff : raw_ext;
				scale_s1 <= ctl.accel_cal_en ? {1'b0, cfg.scale} : SCALE_ONE;
			end else begin
				diff_s1  <= ctl.gyro_cal_en ? gyro_diff : raw_ext;
				scale_s1 <= SCALE_ONE;
			end
			sprod_s2 <= diff_s1 * scale_s1;
			corr_s3  <= CORR_W'(sprod_rnd >>> COEF_FRAC);
			for (int r = 0; r < NUM_AXES; r++) begin
				prod_s4[r] <= $signed(cfg.mcol[r]) * corr_s3;
			end
		end
	end

	assign prod = prod_s4;

endmodule

// ===== src/icr_merge.sv =====
// ----------------------------------------------------------------------------
// icr_merge: combines the lane products into body-frame axes
// registered row sums, then round-half-up and saturation
// ----------------------------------------------------------------------------
module icr_merge
	import icr_pkg::*;
(
	input  logic                       clk,
	input  logic                       en,
	input  prod_col_t [NUM_AXES-1:0]   prod,
	output sample_vec_t                body,
	output logic                       sat
);

	localparam logic signed [SUM_W-1:0] SUM_HALF = SUM_W'(1) << (COEF_FRAC - 1);
	localparam logic signed [RND_W-1:0] BODY_MAX = RND_W'(SAMPLE_MAX);
	localparam logic signed [RND_W-1:0] BODY_MIN = RND_W'(SAMPLE_MIN);

	logic [NUM_AXES-1:0][SUM_W-1:0] sum_next;
	logic [NUM_AXES-1:0][SUM_W-1:0] sum_s5;

	// row r adds the r-th product of every lane
	always_comb begin
		logic signed [SUM_W-1:0] acc;
		for (int r = 0; r < NUM_AXES; r++) begin
			acc = '0;
			for (int j = 0; j < NUM_AXES; j++) begin
				acc = acc + SUM_W'($signed(prod[j][r]));
			end
			sum_next[r] = acc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s5 <= sum_next;
		end
	end

	always_comb begin
		logic signed [RND_W-1:0] rnd;
		sat = 1'b0;
		for (int r = 0; r < NUM_AXES; r++) begin
			rnd = RND_W'(($signed(sum_s5[r]) + SUM_HALF) >>> COEF_FRAC);
			if (rnd > BODY_MAX) begin
				body[r] = SAMPLE_MAX;
				sat     = 1'b1;
			end else if (rnd < BODY_MIN) begin
				body[r] = SAMPLE_MIN;
				sat     = 1'b1;
			end else begin
				body[r] = rnd[SAMPLE_W-1:0];
			end
		end
	end

endmodule

// ===== src/imu_calibrate_and_rotate.sv =====
// ----------------------------------------------------------------------------
// imu_calibrate_and_rotate: imu sample calibration and body-frame rotation
// per-axis offset/scale correction in three lanes, 3x3 rotation, saturation
// ----------------------------------------------------------------------------
//
//  channel   handshake                     payload
//  -------   ---------------------------   ----------------------------------
//  sample    sample_valid / sample_ready   opcode, raw_x, raw_y, raw_z
//  result    result_valid / result_ready   kind, body_x/y/z, saturated
//  config    cfg_we                        cfg_index, cfg_wdata (no read-back)
//
//  one request per cycle while sample_ready is high; a result passes the lane
//  stages s1..s4, the row sum s5 and then the output register
//  throughput is set by the lane multipliers, each fully pipelined
//  reset loads identity matrix, unit scales, zero offsets, calibration off
//  when the consumer stalls, one result waits in a skid register and the whole
//  pipeline freezes until it drains; sample_ready comes straight from a flop
//
module imu_calibrate_and_rotate
	import icr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  sample_in_t           sample,

	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result,

	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	// configuration registers
	sample_vec_t                      accel_off_q;
	coef_vec_t                        accel_scale_q;
	logic                             accel_cal_en_q;
	sample_vec_t                      gyro_off_q;
	logic                             gyro_cal_en_q;
	logic [NUM_AXES-1:0][NUM_AXES-1:0][COEF_W-1:0] rot_q;   // rot_q[row][col]

	// pipeline control: valid and sensor kind travel beside the lanes
	logic  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	kind_t kind_s1, kind_s2, kind_s3, kind_s4, kind_s5;

	// output register and skid
	logic    out_valid_q;
	result_t out_q;
	logic    skid_valid_q;
	result_t skid_q;

	logic                     en;
	lane_ctl_t                lane_ctl;
	sample_vec_t              raw_vec;
	prod_col_t [NUM_AXES-1:0] lane_prod;
	sample_vec_t              body;
	logic                     body_sat;
	result_t                  res_next;
	logic                     out_free;

	// pipeline moves whenever the skid is empty
	assign en           = ~skid_valid_q;
	assign sample_ready = en;

	// ---------------------------------------------------------------------
	// configuration writes, only while the block is idle; the block does not enforce it
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_off_q    <= '0;
			accel_cal_en_q <= 1'b0;
			gyro_off_q     <= '0;
			gyro_cal_en_q  <= 1'b0;
			for (int a = 0; a < NUM_AXES; a++) begin
				accel_scale_q[a] <= COEF_ONE;
				for (int c = 0; c < NUM_AXES; c++) begin
					rot_q[a][c] <= (a == c) ? COEF_ONE : '0;
				end
			end
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ACCEL_OFFSETS: accel_off_q    <= cfg_wdata[NUM_AXES*SAMPLE_W-1:0];
				REG_ACCEL_SCALES:  accel_scale_q  <= cfg_wdata[NUM_AXES*COEF_W-1:0];
				REG_ACCEL_CAL_EN:  accel_cal_en_q <= cfg_wdata[0];
				REG_GYRO_OFFSETS:  gyro_off_q     <= cfg_wdata[NUM_AXES*SAMPLE_W-1:0];
				REG_GYRO_CAL_EN:   gyro_cal_en_q  <= cfg_wdata[0];
				REG_ROT_ROW0:      rot_q[0]       <= cfg_wdata[NUM_AXES*COEF_W-1:0];
				REG_ROT_ROW1:      rot_q[1]       <= cfg_wdata[NUM_AXES*COEF_W-1:0];
				REG_ROT_ROW2:      rot_q[2]       <= cfg_wdata[NUM_AXES*COEF_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// lanes: one per sensor axis, each owning one matrix column
	// ---------------------------------------------------------------------
	assign lane_ctl = '{kind: sample.opcode, accel_cal_en: accel_cal_en_q,
		gyro_cal_en: gyro_cal_en_q};
	assign raw_vec  = {sample.raw_z, sample.raw_y, sample.raw_x};

	for (genvar j = 0; j < NUM_AXES; j++) begin : g_lane
		lane_cfg_t lane_cfg;

		always_comb begin
			lane_cfg.accel_off = accel_off_q[j];
			lane_cfg.gyro_off  = gyro_off_q[j];
			lane_cfg.scale     = accel_scale_q[j];
			for (int r = 0; r < NUM_AXES; r++) begin
				lane_cfg.mcol[r] = rot_q[r][j];
			end
		end

		icr_lane u_lane (
			.clk  (clk),
			.en   (en),
			.ctl  (lane_ctl),
			.raw  (raw_vec[j]),
			.cfg  (lane_cfg),
			.prod (lane_prod[j])
		);
	end

	// ---------------------------------------------------------------------
	// merge: row sums, rounding and saturation
	// ---------------------------------------------------------------------
	icr_merge u_merge (
		.clk  (clk),
		.en   (en),
		.prod (lane_prod),
		.body (body),
		.sat  (body_sat)
	);

	// valid and kind follow the data through the five stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= sample_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= sample.opcode;
			kind_s2 <= kind_s1;
			kind_s3 <= kind_s2;
			kind_s4 <= kind_s3;
			kind_s5 <= kind_s4;
		end
	end

	// ---------------------------------------------------------------------
	// output register with skid
	// ---------------------------------------------------------------------
	assign res_next = '{kind: kind_s5, body_x: body[0], body_y: body[1],
		body_z: body[2], saturated: body_sat};
	assign out_free = ~out_valid_q | result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			// skid drains first; pipeline is frozen while it holds a result
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= vld_s5;
			end
		end else if (en && vld_s5) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res_next;
		end else if (en && vld_s5) begin
			skid_q <= res_next;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// ---------------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------------

	// the skid only holds a result behind a waiting output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a result while the output register is empty");

	// the skid fills only when the output was stalled
	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !result_ready))
		else $error("skid filled without an output stall");

	// a saturated result carries a clipped axis
	a_sat_clipped: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.saturated) |->
			(result.body_x == SAMPLE_MAX || result.body_x == SAMPLE_MIN ||
			 result.body_y == SAMPLE_MAX || result.body_y == SAMPLE_MIN ||
			 result.body_z == SAMPLE_MAX || result.body_z == SAMPLE_MIN))
		else $error("saturation flag set with no axis at the range limit");

endmodule

// ===== test/tb_imu_calibrate_and_rotate.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_imu_calibrate_and_rotate: self-checking bench for the calibrate-and-rotate block
// a queue-fed driver offers samples with random gaps and a monitor drains
// results with random stalls. Every result is checked field by field against
// an in-bench fixed-point predictor. The bench walks through directed and
// random register settings and includes one long consumer stall.
// ----------------------------------------------------------------------------
module tb_imu_calibrate_and_rotate;
	import icr_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
	localparam int CHOKE_CYCLES = 300;     // long consumer hold-off
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_ITEMS  = 80;
	localparam int DRAIN_CYCLES = 20;      // pipeline is five deep plus output register and skid

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 sample_valid = 1'b0;
	logic                 sample_ready;
	sample_in_t           sample       = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	result_t              result;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [CFG_W-1:0]     cfg_wdata    = '0;

	// bench copy of the register file, loaded with the reset values
	logic [NUM_AXES*SAMPLE_W-1:0] cal_accel_off = '0;
	logic [NUM_AXES*COEF_W-1:0]   cal_accel_scale = {COEF_ONE, COEF_ONE, COEF_ONE};
	logic                         cal_accel_en  = 1'b0;
	logic [NUM_AXES*SAMPLE_W-1:0] cal_gyro_off  = '0;
	logic                         cal_gyro_en   = 1'b0;
	logic [NUM_AXES*COEF_W-1:0]   rot_row [NUM_AXES] = '{
		{16'h0000, 16'h0000, COEF_ONE},
		{16'h0000, COEF_ONE, 16'h0000},
		{COEF_ONE, 16'h0000, 16'h0000}
	};

	sample_in_t sample_q [$];   // requests still to be offered
	result_t    body_q [$];     // predicted results, oldest first

	int      err_cnt     = 0;
	int      cycle_cnt   = 0;
	int      offer_wait  = 0;
	int      drain_wait  = 0;
	int      choke_cnt   = 0;
	logic    burst       = 1'b0;  // no idling on either side
	logic    choke_go    = 1'b0;
	logic    choke_done  = 1'b0;
	result_t want;

	imu_calibrate_and_rotate dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	// round half up: floor((v + half) / 2^F), arithmetic shift gives the floor
	function automatic longint round_q(longint v);
		return (v + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
	endfunction

	// calibrate one sample, rotate it into the body frame and saturate each axis
	function automatic result_t rotate_to_body(sample_in_t s);
		longint  raw [NUM_AXES];
		longint  corr [NUM_AXES];
		longint  off, sc, m, acc, r;
		logic    sat;
		result_t o;
		sat    = 1'b0;
		raw[0] = s.raw_x;
		raw[1] = s.raw_y;
		raw[2] = s.raw_z;
		for (int i = 0; i < NUM_AXES; i++) begin
			if (s.opcode == KIND_ACCEL) begin
				if (cal_accel_en) begin
					off     = $signed(cal_accel_off[i*SAMPLE_W +: SAMPLE_W]);
					sc      = cal_accel_scale[i*COEF_W +: COEF_W];
					corr[i] = round_q((raw[i] - off) * sc);
				end else begin
					corr[i] = raw[i];
				end
			end else begin
				if (cal_gyro_en) begin
					off     = $signed(cal_gyro_off[i*SAMPLE_W +: SAMPLE_W]);
					corr[i] = raw[i] - off;
				end else begin
					corr[i] = raw[i];
				end
			end
		end
		o.kind = s.opcode;
		for (int i = 0; i < NUM_AXES; i++) begin
			acc = 0;
			for (int j = 0; j < NUM_AXES; j++) begin
				m   = $signed(rot_row[i][j*COEF_W +: COEF_W]);
				acc = acc + m * corr[j];
			end
			r = round_q(acc);
			if (r > longint'(SAMPLE_MAX)) begin
				r   = SAMPLE_MAX;
				sat = 1'b1;
			end else if (r < longint'(SAMPLE_MIN)) begin
				r   = SAMPLE_MIN;
				sat = 1'b1;
			end
			case (i)
				0: o.body_x = sample_t'(r);
				1: o.body_y = sample_t'(r);
				default: o.body_z = sample_t'(r);
			endcase
		end
		o.saturated = sat;
		return o;
	endfunction

	// ------------------------------------------------------------------------
	// request driver: one queued item at a time, random gap before each
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample       <= '0;
			offer_wait = 0;
		end else begin
			// request taken at this edge: predict it with the current settings
			if (sample_valid && sample_ready) begin
				body_q.push_back(rotate_to_body(sample));
				offer_wait = burst ? 0 : $urandom_range(0, 10);
			end
			if (sample_valid && !sample_ready) begin
				// still waiting, payload stays put
			end else if (offer_wait != 0) begin
				sample_valid <= 1'b0;
				offer_wait--;
			end else if (sample_q.size() != 0) begin
				sample       <= sample_q.pop_front();
				sample_valid <= 1'b1;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// result monitor: compares against the oldest prediction, stalls at random
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			drain_wait = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (body_q.size() == 0) begin
					$error("unexpected result: kind %0d body %0d %0d %0d sat %0d",
						result.kind, result.body_x, result.body_y, result.body_z,
						result.saturated);
					err_cnt++;
				end else begin
					want = body_q.pop_front();
					if (result.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, result.kind);
						err_cnt++;
					end
					if (result.body_x !== want.body_x) begin
						$error("body_x: expected %0d, got %0d", want.body_x, result.body_x);
						err_cnt++;
					end
					if (result.body_y !== want.body_y) begin
						$error("body_y: expected %0d, got %0d", want.body_y, result.body_y);
						err_cnt++;
					end
					if (result.body_z !== want.body_z) begin
						$error("body_z: expected %0d, got %0d", want.body_z, result.body_z);
						err_cnt++;
					end
					if (result.saturated !== want.saturated) begin
						$error("saturated: expected %0d, got %0d", want.saturated,
							result.saturated);
						err_cnt++;
					end
				end
				drain_wait = burst ? 0 : $urandom_range(0, 10);
			end
			// one long hold-off so the pipeline backs up into the request side
			if (choke_go && !choke_done) begin
				result_ready <= 1'b0;
				choke_cnt++;
				if (choke_cnt == CHOKE_CYCLES)
					choke_done = 1'b1;
			end else if (drain_wait != 0) begin
				result_ready <= 1'b0;
				drain_wait--;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb_imu_calibrate_and_rotate: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	// register write, mirrored into the bench copy with the same masking
	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_ACCEL_OFFSETS: cal_accel_off   = val[NUM_AXES*SAMPLE_W-1:0];
			REG_ACCEL_SCALES:  cal_accel_scale = val[NUM_AXES*COEF_W-1:0];
			REG_ACCEL_CAL_EN:  cal_accel_en    = val[0];
			REG_GYRO_OFFSETS:  cal_gyro_off    = val[NUM_AXES*SAMPLE_W-1:0];
			REG_GYRO_CAL_EN:   cal_gyro_en     = val[0];
			REG_ROT_ROW0:      rot_row[0]      = val[NUM_AXES*COEF_W-1:0];
			REG_ROT_ROW1:      rot_row[1]      = val[NUM_AXES*COEF_W-1:0];
			REG_ROT_ROW2:      rot_row[2]      = val[NUM_AXES*COEF_W-1:0];
			default: ;
		endcase
	endtask

	// full register set; only called with the block drained
	task automatic program_regs(logic [CFG_W-1:0] a_off, logic [CFG_W-1:0] a_sc,
			logic [CFG_W-1:0] a_en, logic [CFG_W-1:0] g_off, logic [CFG_W-1:0] g_en,
			logic [CFG_W-1:0] r0, logic [CFG_W-1:0] r1, logic [CFG_W-1:0] r2);
		write_reg(REG_ACCEL_OFFSETS, a_off);
		write_reg(REG_ACCEL_SCALES, a_sc);
		write_reg(REG_ACCEL_CAL_EN, a_en);
		write_reg(REG_GYRO_OFFSETS, g_off);
		write_reg(REG_GYRO_CAL_EN, g_en);
		write_reg(REG_ROT_ROW0, r0);
		write_reg(REG_ROT_ROW1, r1);
		write_reg(REG_ROT_ROW2, r2);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic queue_sample(kind_t k, sample_t x, sample_t y, sample_t z);
		sample_in_t s;
		s.opcode = k;
		s.raw_x  = x;
		s.raw_y  = y;
		s.raw_z  = z;
		sample_q.push_back(s);
	endtask

	// all requests offered, taken and answered
	task automatic wait_drained();
		while (sample_q.size() != 0 || sample_valid || body_q.size() != 0)
			@(negedge clk);
	endtask

	// samples lean on the range ends and on small values
	function automatic sample_t rand_sample();
		case ($urandom_range(0, 7))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return sample_t'($urandom_range(0, 64)) - sample_t'(32);
			3: return sample_t'($urandom_range(0, 4095));
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic coef_t rand_coef();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return COEF_ONE;
			3: return 16'hC000;       // minus one in the matrix format
			4: return 16'hFFFF;
			5: return 16'h0000;
			6, 7: return coef_t'($urandom_range(0, 16'h4000)) - coef_t'(16'h2000);
			default: return coef_t'($urandom);
		endcase
	endfunction

	// three packed entries with junk in the unused top bits
	function automatic logic [CFG_W-1:0] rand_coef_reg();
		return {12'($urandom), rand_coef(), rand_coef(), rand_coef()};
	endfunction

	function automatic logic [CFG_W-1:0] rand_off_reg();
		return {rand_sample(), rand_sample(), rand_sample()};
	endfunction

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: identity matrix, calibration off
		queue_sample(KIND_ACCEL, SAMPLE_MAX, SAMPLE_MIN, '0);
		queue_sample(KIND_GYRO, SAMPLE_MIN, SAMPLE_MAX, -20'sd1);
		queue_sample(KIND_ACCEL, 20'sd1, -20'sd1, 20'sd12345);
		wait_drained();

		// extremes: offsets at the range ends, largest scale, matrix corners
		program_regs({20'sd1, SAMPLE_MAX, SAMPLE_MIN},
			{12'h000, 16'h0000, 16'h2000, 16'hFFFF},
			60'hABC_DEF0_1234_5671,
			{-20'sd1, SAMPLE_MIN, SAMPLE_MAX},
			60'hFFF_FFFF_FFFF_FFFF,
			{12'hABC, 16'h4000, 16'h8000, 16'h7FFF},
			{12'hFFF, 16'h8000, 16'h8000, 16'h8000},
			{12'h5A5, 16'h7FFF, 16'h4000, 16'h0000});
		queue_sample(KIND_ACCEL, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
		queue_sample(KIND_ACCEL, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
		queue_sample(KIND_ACCEL, '0, '0, '0);
		queue_sample(KIND_ACCEL, 20'sd1, -20'sd1, 20'sd1);
		queue_sample(KIND_GYRO, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
		queue_sample(KIND_GYRO, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
		queue_sample(KIND_GYRO, '0, '0, '0);
		wait_drained();

		// half scale on the identity: exact halves round upwards
		program_regs('0,
			{12'hFFF, 16'h2000, 16'h2000, 16'h2000},
			60'h000_0000_0000_0001,
			{20'sd7, 20'sd7, 20'sd7},
			60'hFFF_FFFF_FFFF_FFFE,   // bit 0 clear, gyro bias off
			{12'hFFF, 16'h0000, 16'h0000, COEF_ONE},
			{12'h000, 16'h0000, COEF_ONE, 16'h0000},
			{12'h800, COEF_ONE, 16'h0000, 16'h0000});
		queue_sample(KIND_ACCEL, 20'sd1, -20'sd1, 20'sd3);
		queue_sample(KIND_ACCEL, -20'sd3, 20'sd2, -20'sd2);
		queue_sample(KIND_GYRO, SAMPLE_MAX, SAMPLE_MIN, 20'sd5);
		wait_drained();

		// random settings, random samples
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			program_regs(rand_off_reg(), rand_coef_reg(),
				CFG_W'({$urandom, $urandom}), rand_off_reg(),
				CFG_W'({$urandom, $urandom}),
				rand_coef_reg(), rand_coef_reg(), rand_coef_reg());
			burst = (ph == 1) || ($urandom_range(0, 3) == 0);
			// second phase: hold the consumer off while requests keep coming
			if (ph == 1)
				choke_go = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++)
				queue_sample(kind_t'($urandom_range(0, 1)), rand_sample(),
					rand_sample(), rand_sample());
			wait_drained();
		end

		burst = 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0 && body_q.size() == 0) begin
			$display("tb_imu_calibrate_and_rotate: clean");
		end else begin
			$display("tb_imu_calibrate_and_rotate: errors");
		end
		$finish;
	end

endmodule

// ===== imu_calibrate_and_rotate.f =====
src/icr_pkg.sv
src/icr_lane.sv
src/icr_merge.sv
src/imu_calibrate_and_rotate.sv
test/tb_imu_calibrate_and_rotate.sv
